/* sv/amaa_pkg.sv */
// Shared constants and the arctangent table for the attitude angle pipeline.
package amaa_pkg;

    localparam int SAMPLE_BITS  = 16;
    localparam int OP_W         = SAMPLE_BITS + 2;      // CORDIC operand width
    localparam int MAG_W        = SAMPLE_BITS + 1;      // operand magnitude width
    localparam int NORM_BIT     = 40;
    localparam int SHIFT_W      = 6;
    localparam int XY_W         = NORM_BIT + 5;         // normalized x/y with growth
    localparam int Z_W          = 30;
    localparam int ANG_FRAC     = 12;
    localparam int CORDIC_STEPS = 24;
    localparam int SQ_STEPS     = SAMPLE_BITS;
    localparam int SQ_W         = 2 * SAMPLE_BITS;
    localparam int SQ_LAT       = SQ_STEPS + 1;
    localparam int COR_LAT      = CORDIC_STEPS + 3;
    localparam int ANG_W        = 16;

    localparam logic signed [Z_W-1:0]   ANG_180   = Z_W'(18000 * 4096);
    localparam logic signed [ANG_W-1:0] DEG_180   = 16'sd18000;
    localparam logic signed [ANG_W-1:0] DEG_90    = 16'sd9000;
    localparam logic signed [ANG_W:0]   DEG_360   = 17'sd36000;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] ax;
        logic signed [SAMPLE_BITS-1:0] ay;
        logic signed [SAMPLE_BITS-1:0] az;
        logic signed [SAMPLE_BITS-1:0] mx;
        logic signed [SAMPLE_BITS-1:0] my;
    } sample_t;

    typedef struct packed {
        logic my_zero;
        logic mx_neg;
    } head_flag_t;

    function automatic logic signed [Z_W-1:0] atan_tab(input int i);
        logic signed [Z_W-1:0] v;
        begin
            case (i)
                0:  v = 30'sd18432000;
                1:  v = 30'sd10881045;
                2:  v = 30'sd5749245;
                3:  v = 30'sd2918407;
                4:  v = 30'sd1464867;
                5:  v = 30'sd733147;
                6:  v = 30'sd366663;
                7:  v = 30'sd183343;
                8:  v = 30'sd91673;
                9:  v = 30'sd45837;
                10: v = 30'sd22918;
                11: v = 30'sd11459;
                12: v = 30'sd5730;
                13: v = 30'sd2865;
                14: v = 30'sd1432;
                15: v = 30'sd716;
                16: v = 30'sd358;
                17: v = 30'sd179;
                18: v = 30'sd90;
                19: v = 30'sd45;
                20: v = 30'sd22;
                21: v = 30'sd11;
                22: v = 30'sd6;
                23: v = 30'sd3;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

/* sv/accel_mag_attitude_angles_top.sv */
// Top level of the roll, pitch and heading pipeline with its stream ports.
//
// Each input word carries one accelerometer and one magnetometer sample; each
// output word carries pitch, roll and heading in signed hundredths of a
// degree. Roll is atan2(accel_y, accel_z), pitch is atan2(-accel_x,
// sqrt(accel_y^2 + accel_z^2)) and heading is atan2(mag_x, mag_y) less the
// declination register, wrapped once into -180..+180 degrees (the atan2 term
// is 180 or 0 degrees when mag_y is zero). The block is a fully pipelined
// datapath: a word can enter every cycle while the output is not stalled.
// The pipeline is 17 stages of the bit-per-stage square root, 27 stages
// of the CORDIC units (two for normalization, 24 rotations, one for
// rounding) and one stage for declination and wrap that is also the output
// register. When the output word is not taken, the whole pipeline holds, so
// s_tready falls only while m_tvalid is high and m_tready is low. Write the
// declination only while no word is in flight; it resets to -11.50 degrees.
module accel_mag_attitude_angles_top
    import amaa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_data,     // declination, signed hundredths of a degree
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,      // accel_x, accel_y, accel_z, mag_x, mag_y, mag_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata       // pitch_angle[14:0], roll_angle, heading_angle, pad
);

    localparam int LAT = SQ_LAT + COR_LAT + 1;

    logic                    en;
    logic [LAT-1:0]          vld_reg;
    logic signed [ANG_W-1:0] decl_reg;
    sample_t                 smp_in;
    sample_t                 smp_reg [0:SQ_LAT-1];
    head_flag_t              hf_reg  [0:COR_LAT-1];
    logic [SAMPLE_BITS-1:0]  root;
    logic signed [ANG_W-1:0] roll_ang;
    logic signed [ANG_W-1:0] pitch_ang;
    logic signed [ANG_W-1:0] head_ang;
    logic signed [ANG_W-1:0] head_raw;
    logic signed [ANG_W:0]   head_diff;
    logic signed [ANG_W-1:0] head_next;
    logic signed [ANG_W-1:0] roll_reg;
    logic signed [14:0]      pitch_reg;
    logic signed [ANG_W-1:0] head_reg;

    // advance everything unless the output word is stuck
    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;

    assign smp_in.ax = s_tdata[15:0];
    assign smp_in.ay = s_tdata[31:16];
    assign smp_in.az = s_tdata[47:32];
    assign smp_in.mx = s_tdata[63:48];
    assign smp_in.my = s_tdata[79:64];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            decl_reg <= -16'sd1150;
        end
        else
        begin
            if (en)
            begin
                vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
            end
            if (cfg_we)
            begin
                decl_reg <= cfg_data;
            end
        end
    end

    // hold the samples beside the square root
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            smp_reg[0] <= smp_in;
            for (int k = 1; k < SQ_LAT; k++)
            begin
                smp_reg[k] <= smp_reg[k-1];
            end
        end
    end

    amaa_isqrt u_isqrt (
        .clk  (clk),
        .en   (en),
        .ay   (smp_in.ay),
        .az   (smp_in.az),
        .root (root)
    );

    sample_t s_cor;
    assign s_cor = smp_reg[SQ_LAT-1];

    amaa_cordic u_roll (
        .clk   (clk),
        .en    (en),
        .y_in  (OP_W'(s_cor.ay)),
        .x_in  (OP_W'(s_cor.az)),
        .angle (roll_ang)
    );

    amaa_cordic u_pitch (
        .clk   (clk),
        .en    (en),
        .y_in  (-OP_W'(s_cor.ax)),
        .x_in  ($signed({2'b00, root})),
        .angle (pitch_ang)
    );

    amaa_cordic u_head (
        .clk   (clk),
        .en    (en),
        .y_in  (OP_W'(s_cor.mx)),
        .x_in  (OP_W'(s_cor.my)),
        .angle (head_ang)
    );

    // carry the zero mag_y override alongside the CORDIC units
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hf_reg[0].my_zero <= (s_cor.my == '0);
            hf_reg[0].mx_neg  <= s_cor.mx[SAMPLE_BITS-1];
            for (int k = 1; k < COR_LAT; k++)
            begin
                hf_reg[k] <= hf_reg[k-1];
            end
        end
    end

    // subtract declination and wrap once
    always_comb
    begin
        if (hf_reg[COR_LAT-1].my_zero)
        begin
            head_raw = hf_reg[COR_LAT-1].mx_neg ? DEG_180 : '0;
        end
        else
        begin
            head_raw = head_ang;
        end
        head_diff = (ANG_W+1)'(head_raw) - (ANG_W+1)'(decl_reg);
        if (head_diff > (ANG_W+1)'(DEG_180))
        begin
            head_next = ANG_W'(head_diff - DEG_360);
        end
        else if (head_diff < -(ANG_W+1)'(DEG_180))
        begin
            head_next = ANG_W'(head_diff + DEG_360);
        end
        else
        begin
            head_next = ANG_W'(head_diff);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= roll_ang;
            pitch_reg <= pitch_ang[14:0];
            head_reg  <= head_next;
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = {1'b0, head_reg, roll_reg, pitch_reg};

`ifndef SYNTH
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[46:31]) <= 16'sd18000
                      && $signed(m_tdata[46:31]) >= -16'sd18000))
        else $error("heading out of range");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[14:0]) <= 15'sd9000
                      && $signed(m_tdata[14:0]) >= -15'sd9000))
        else $error("pitch out of range");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while output stalled");
`endif

endmodule

/* sv/amaa_isqrt.sv */
// Pipelined integer square root of ay^2 + az^2, one result bit per stage.
module amaa_isqrt
    import amaa_pkg::*;
(
    input  logic                          clk,
    input  logic                          en,
    input  logic signed [SAMPLE_BITS-1:0] ay,
    input  logic signed [SAMPLE_BITS-1:0] az,
    output logic [SAMPLE_BITS-1:0]        root
);

    logic [SQ_W-1:0] op_reg  [0:SQ_STEPS];
    logic [SQ_W-1:0] res_reg [0:SQ_STEPS];
    logic signed [SQ_W-1:0] sq_y;
    logic signed [SQ_W-1:0] sq_z;

    assign sq_y = SQ_W'(ay) * SQ_W'(ay);
    assign sq_z = SQ_W'(az) * SQ_W'(az);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_reg[0]  <= SQ_W'(sq_y) + SQ_W'(sq_z);
            res_reg[0] <= '0;
        end
    end

    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_step
        localparam logic [SQ_W-1:0] ONE = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        logic [SQ_W-1:0] trial;
        logic [SQ_W-1:0] op_next;
        logic [SQ_W-1:0] res_next;

        always_comb
        begin
            trial = res_reg[k] + ONE;
            if (op_reg[k] >= trial)
            begin
                op_next  = op_reg[k] - trial;
                res_next = (res_reg[k] >> 1) + ONE;
            end
            else
            begin
                op_next  = op_reg[k];
                res_next = res_reg[k] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                op_reg[k+1]  <= op_next;
                res_reg[k+1] <= res_next;
            end
        end
    end

    assign root = res_reg[SQ_STEPS][SAMPLE_BITS-1:0];

endmodule

/* sv/amaa_cordic.sv */
// Pipelined vectoring CORDIC atan2 in hundredths of a degree.
module amaa_cordic
    import amaa_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [OP_W-1:0]  y_in,
    input  logic signed [OP_W-1:0]  x_in,
    output logic signed [ANG_W-1:0] angle
);

    // normalize: find length of the larger magnitude
    logic [MAG_W-1:0]       mag_x;
    logic [MAG_W-1:0]       mag_y;
    logic [MAG_W-1:0]       mag_m;
    logic [SHIFT_W-1:0]     len;
    logic                   spec_a;
    logic signed [ANG_W-1:0] spec_val_a;

    logic signed [OP_W-1:0]    xa_reg;
    logic signed [OP_W-1:0]    ya_reg;
    logic [SHIFT_W-1:0]        sh_reg;

    logic signed [XY_W-1:0]    x_reg [0:CORDIC_STEPS];
    logic signed [XY_W-1:0]    y_reg [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]     z_reg [0:CORDIC_STEPS];
    logic                      spec_reg [0:CORDIC_STEPS+1];
    logic signed [ANG_W-1:0]   sval_reg [0:CORDIC_STEPS+1];
    logic signed [ANG_W-1:0]   angle_reg;

    always_comb
    begin
        mag_x = x_in[OP_W-1] ? MAG_W'(-x_in) : MAG_W'(x_in);
        mag_y = y_in[OP_W-1] ? MAG_W'(-y_in) : MAG_W'(y_in);
        mag_m = (mag_x > mag_y) ? mag_x : mag_y;
        len   = '0;
        for (int b = 0; b < MAG_W; b++)
        begin
            if (mag_m[b])
            begin
                len = SHIFT_W'(b + 1);
            end
        end
        spec_a     = 1'b1;
        spec_val_a = '0;
        if (y_in == '0)
        begin
            spec_val_a = x_in[OP_W-1] ? DEG_180 : '0;
        end
        else if (x_in == '0)
        begin
            spec_val_a = y_in[OP_W-1] ? -DEG_90 : DEG_90;
        end
        else
        begin
            spec_a = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xa_reg      <= x_in;
            ya_reg      <= y_in;
            sh_reg      <= SHIFT_W'(NORM_BIT + 1) - len;
            spec_reg[0] <= spec_a;
            sval_reg[0] <= spec_val_a;
        end
    end

    // scale and pre-rotate a negative x by 180 degrees
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    assign xs = XY_W'(xa_reg) <<< sh_reg;
    assign ys = XY_W'(ya_reg) <<< sh_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (xs < 0)
            begin
                x_reg[0] <= -xs;
                y_reg[0] <= -ys;
                z_reg[0] <= (ys >= 0) ? ANG_180 : -ANG_180;
            end
            else
            begin
                x_reg[0] <= xs;
                y_reg[0] <= ys;
                z_reg[0] <= '0;
            end
            spec_reg[1] <= spec_reg[0];
            sval_reg[1] <= sval_reg[0];
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;

        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + atan_tab(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - atan_tab(i);
                end
                spec_reg[i+2] <= spec_reg[i+1];
                sval_reg[i+2] <= sval_reg[i+1];
            end
        end
    end

    // round half up to hundredths and clamp
    logic signed [Z_W-1:0] z_rnd;

    assign z_rnd = (z_reg[CORDIC_STEPS] + Z_W'(1 << (ANG_FRAC - 1))) >>> ANG_FRAC;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (spec_reg[CORDIC_STEPS+1])
            begin
                angle_reg <= sval_reg[CORDIC_STEPS+1];
            end
            else if (z_rnd > Z_W'(DEG_180))
            begin
                angle_reg <= DEG_180;
            end
            else if (z_rnd < -Z_W'(DEG_180))
            begin
                angle_reg <= -DEG_180;
            end
            else
            begin
                angle_reg <= ANG_W'(z_rnd);
            end
        end
    end

    assign angle = angle_reg;

endmodule

/* tb/sv/tb_top.sv */
// Testbench for the roll, pitch and heading stream pipeline.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import amaa_pkg::*;

    // One predicted output word, at the widths of the result fields.
    typedef struct packed {
        logic signed [15:0] heading;
        logic signed [15:0] roll;
        logic signed [14:0] pitch;
    } angles_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    accel_mag_attitude_angles_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Arctangent steps in 1/4096 of a hundredth of a degree.
    longint atan_steps [CORDIC_STEPS] = '{
        18432000, 10881045, 5749245, 2918407, 1464867, 733147, 366663, 183343,
        91673, 45837, 22918, 11459, 5730, 2865, 1432, 716,
        358, 179, 90, 45, 22, 11, 6, 3
    };

    angles_t angles_due[$];       // predicted words, oldest first
    longint  declination_now;     // our copy of the declination register
    int      errors;
    bit      steady_source;       // when set, send words back to back
    bit      steady_sink;         // when set, never stall the output

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Vectoring CORDIC arctangent, in hundredths of a degree.
    function automatic longint arc_hundredths(longint y, longint x);
        longint mag_max;
        longint z;
        longint t;
        longint dx;
        longint dy;
        int     len;
        int     sh;
        if (y == 0)
            return (x < 0) ? 18000 : 0;
        if (x == 0)
            return (y > 0) ? 9000 : -9000;
        mag_max = ((x < 0) ? -x : x) > ((y < 0) ? -y : y) ? ((x < 0) ? -x : x)
                                                            : ((y < 0) ? -y : y);
        len = 0;
        while (len < 64 && (mag_max >> len) != 0)
            len++;
        sh = (len <= NORM_BIT + 1) ? (NORM_BIT + 1 - len) : 0;
        x = x <<< sh;
        y = y <<< sh;
        z = 0;
        // Fold the left half plane over by half a turn.
        if (x < 0) begin
            z = (y >= 0) ? longint'(18000) * 4096 : -longint'(18000) * 4096;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x = x + dx;
                y = y - dy;
                z = z + atan_steps[i];
            end else begin
                x = x - dx;
                y = y + dy;
                z = z - atan_steps[i];
            end
        end
        t = (z + (longint'(1) << (ANG_FRAC - 1))) >>> ANG_FRAC;
        if (t > 18000)
            t = 18000;
        if (t < -18000)
            t = -18000;
        return t;
    endfunction

    function automatic longint floor_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic angles_t predict_angles(logic [95:0] word);
        longint ax;
        longint ay;
        longint az;
        longint mx;
        longint my;
        longint head;
        angles_t a;
        ax = longint'($signed(word[15:0]));
        ay = longint'($signed(word[31:16]));
        az = longint'($signed(word[47:32]));
        mx = longint'($signed(word[63:48]));
        my = longint'($signed(word[79:64]));
        a.roll  = 16'(arc_hundredths(ay, az));
        a.pitch = 15'(arc_hundredths(-ax, floor_sqrt(longint'(ay * ay + az * az))));
        if (my == 0)
            head = (mx < 0) ? 18000 : 0;
        else
            head = arc_hundredths(mx, my);
        head = head - declination_now;
        // Wrap once back into -180..+180 degrees.
        if (head > 18000)
            head = head - 36000;
        else if (head < -18000)
            head = head + 36000;
        a.heading = 16'(head);
        return a;
    endfunction

    function automatic int gap_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return 0;
        if (pick < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Send one word; return once it has been accepted.
    task automatic send_sample(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic [15:0] mx,
                               input logic [15:0] my, input logic [15:0] mz);
        int gap;
        gap = steady_source ? 0 : gap_len();
        repeat (gap) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {mz, my, mx, az, ay, ax};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        angles_due.push_back(predict_angles({mz, my, mx, az, ay, ax}));
    endtask

    task automatic send_random_sample();
        send_sample(16'($urandom()), 16'($urandom()), 16'($urandom()),
                    16'($urandom()), 16'($urandom()), 16'($urandom()));
    endtask

    // Drain the pipeline, then let the declination change.
    task automatic write_declination(input logic signed [15:0] value);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (angles_due.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        declination_now = longint'(value);
    endtask

    // Extremes of every field and each exact-axis case.
    task automatic test_directed();
        send_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
        send_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001);
        // Roll on the z axis: zero y, both signs of z.
        send_sample(16'h0005, 16'h0000, 16'h1000, 16'h0001, 16'h0001, 16'h0000);
        send_sample(16'hFFFB, 16'h0000, 16'hF000, 16'hFFFF, 16'h0001, 16'h0000);
        // Roll on the y axis with zero z; pitch then has zero magnitude below.
        send_sample(16'h0000, 16'h2000, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000);
        send_sample(16'h0000, 16'hE000, 16'h0000, 16'h0001, 16'hFFFF, 16'h0000);
        send_sample(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
        send_sample(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000);
        // Heading with mag_y zero: negative, zero and positive mag_x.
        send_sample(16'h0100, 16'h0100, 16'h0100, 16'hFFFF, 16'h0000, 16'h1234);
        send_sample(16'h0100, 16'h0100, 16'h0100, 16'h0000, 16'h0000, 16'h1234);
        send_sample(16'h0100, 16'h0100, 16'h0100, 16'h0001, 16'h0000, 16'h1234);
        send_sample(16'h0100, 16'h0100, 16'h0100, 16'h8000, 16'h0000, 16'h1234);
        // Heading with mag_x zero, and both halves of the left half plane.
        send_sample(16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'h7FFF, 16'h0000);
        send_sample(16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'h8000, 16'h0000);
        send_sample(16'h0001, 16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000);
        send_sample(16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_sample(16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0000);
    endtask

    // Wrap at both ends: heading near +-180 with extreme declinations.
    task automatic test_declination_extremes();
        write_declination(-16'sd18000);
        send_sample(16'h0000, 16'h0001, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0001, 16'h0001, 16'h0001, 16'hFFFF, 16'h0000);
        repeat (40) send_random_sample();
        write_declination(16'sd18000);
        send_sample(16'h0000, 16'h0001, 16'h0001, 16'hFFFF, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0001, 16'h0001, 16'h0001, 16'h0000, 16'h0000);
        send_sample(16'h0000, 16'h0001, 16'h0001, 16'hFFFF, 16'hFFFF, 16'h0000);
        repeat (40) send_random_sample();
        write_declination(16'sd0);
        repeat (40) send_random_sample();
    endtask

    // Random words: full range, small magnitudes and axis-aligned ones.
    task automatic test_random(input int count);
        logic [15:0] f [6];
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 6; k++) begin
                if (kind < 5)
                    f[k] = 16'($urandom());
                else if (kind < 8)
                    f[k] = 16'($signed($urandom_range(0, 64)) - 32);
                else
                    f[k] = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom());
            end
            send_sample(f[0], f[1], f[2], f[3], f[4], f[5]);
            // Switch idling modes now and then so long stretches run flat out.
            if (n % 100 == 0) begin
                steady_source = ($urandom_range(0, 3) == 0);
                steady_sink   = ($urandom_range(0, 3) == 0);
            end
        end
    endtask

    task automatic test_declination_sweep();
        for (int p = 0; p < 4; p++) begin
            write_declination(16'($signed($urandom_range(0, 36000)) - 18000));
            test_random(300);
        end
    endtask

    // Output stall pattern: mostly short stalls, now and then a long one.
    initial begin
        int stall;
        m_tready = 1'b0;
        stall = 0;
        forever begin
            @(negedge clk);
            if (steady_sink) begin
                m_tready <= 1'b1;
                stall = 0;
            end else if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
                stall = gap_len();
            end
        end
    end

    // Compare each output word with the oldest prediction.
    initial begin
        angles_t want;
        angles_t got;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                got = angles_t'(m_tdata[46:0]);
                if (angles_due.size() == 0) begin
                    $display("%0t: unexpected word pitch %0d roll %0d heading %0d",
                             $time, got.pitch, got.roll, got.heading);
                    errors++;
                end else begin
                    want = angles_due.pop_front();
                    if (got.pitch !== want.pitch) begin
                        $display("%0t: pitch expected %0d actual %0d",
                                 $time, want.pitch, got.pitch);
                        errors++;
                    end
                    if (got.roll !== want.roll) begin
                        $display("%0t: roll expected %0d actual %0d",
                                 $time, want.roll, got.roll);
                        errors++;
                    end
                    if (got.heading !== want.heading) begin
                        $display("%0t: heading expected %0d actual %0d",
                                 $time, want.heading, got.heading);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        errors          = 0;
        steady_source   = 1'b0;
        steady_sink     = 1'b0;
        declination_now = -1150;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = 16'h0000;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed();
        test_random(300);
        test_declination_extremes();
        test_declination_sweep();

        // Drop valid and drain what is still in flight.
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (angles_due.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
